// ===== src/assert_macros.svh =====
// Assertion macros used by the port checker module.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, muted during reset
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, muted during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== src/hmca_pkg.sv =====
// Shared types, constants and helpers for the min-cost assignment block.
// No dependencies.
package hmca_pkg;

    localparam int MAX_SIZE = 64;
    localparam int IDX_W    = $clog2(MAX_SIZE);
    localparam int CNT_W    = IDX_W + 1;
    localparam int COST_W   = 24;
    localparam int POT_W    = 40;
    localparam int CFG_W    = 7;

    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic signed [POT_W-1:0] pot_t;

    // 1e6 in Q32.8
    localparam pot_t FORBID_COST = 40'sd256000000;
    localparam pot_t P_INF       = {1'b0, {(POT_W-1){1'b1}}};

    localparam logic [0:0] REG_ROWS = 1'b0;
    localparam logic [0:0] REG_COLS = 1'b1;

    typedef enum logic [4:0] {
        OP_IDLE, OP_START, OP_CLR, OP_PH, OP_MINI, OP_GRD, OP_GCHK,
        OP_SRD, OP_SCUR, OP_SCMP, OP_NOP, OP_URD, OP_UB, OP_UC, OP_GNXT,
        OP_PRD, OP_PP, OP_PW, OP_OCLR, OP_ORD, OP_OW, OP_TRD, OP_TLD, OP_TWAIT
    } op_t;

    typedef struct packed {
        op_t  op;
        cnt_t j;
        cnt_t i;
    } cmd_t;

    typedef struct packed {
        cnt_t s;
        cnt_t n;
        logic used_j;
        logic i0_bad;
        logic j1_zero;
        logic j0_zero;
        logic out_acc;
    } stat_t;

    // 0 acts as 1, above MAX_SIZE acts as MAX_SIZE
    function automatic cnt_t clamp_dim(input cnt_t v);
        cnt_t r;
        if (v == '0) begin
            r = cnt_t'(1);
        end else if (v > cnt_t'(MAX_SIZE)) begin
            r = cnt_t'(MAX_SIZE);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== src/hmca_ctrl.sv =====
// Sequencer for load, solve and result phases.
// Depends on hmca_pkg.
module hmca_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_acc,
    input  logic           s_final,
    input  hmca_pkg::stat_t st,
    output hmca_pkg::cmd_t  cmd,
    output logic           s_ready
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_START, ST_CLR, ST_PH, ST_MINI, ST_GRD, ST_GCHK,
        ST_SRD, ST_SCUR, ST_SCMP, ST_SEND, ST_URD, ST_UB, ST_UC, ST_GNXT,
        ST_PCHK, ST_PRD, ST_PP, ST_PW, ST_NXT, ST_OCLR, ST_ORD, ST_OW,
        ST_TRD, ST_TLD, ST_TWAIT
    } state_t;

    state_t          state_reg, state_next;
    hmca_pkg::cnt_t  j_reg, j_next;
    hmca_pkg::cnt_t  i_reg, i_next;
    hmca_pkg::cnt_t  g_reg, g_next;

    always_comb begin
        state_next = state_reg;
        j_next     = j_reg;
        i_next     = i_reg;
        g_next     = g_reg;
        unique case (state_reg)
            ST_IDLE: if (s_acc && s_final) state_next = ST_START;
            ST_START: begin
                state_next = ST_CLR;
                j_next     = '0;
                i_next     = hmca_pkg::cnt_t'(1);
            end
            ST_CLR: begin
                if (j_reg == st.s) state_next = ST_PH;
                else j_next = j_reg + 1'b1;
            end
            ST_PH: begin
                state_next = ST_MINI;
                j_next     = '0;
            end
            ST_MINI: begin
                if (j_reg == st.s) begin
                    state_next = ST_GRD;
                    g_next     = '0;
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_GRD: state_next = ST_GCHK;
            ST_GCHK: begin
                if (st.i0_bad) begin
                    state_next = ST_PCHK;
                    g_next     = '0;
                end else begin
                    state_next = ST_SRD;
                    j_next     = hmca_pkg::cnt_t'(1);
                end
            end
            ST_SRD: begin
                if (!st.used_j) state_next = ST_SCUR;
                else if (j_reg == st.s) state_next = ST_SEND;
                else j_next = j_reg + 1'b1;
            end
            ST_SCUR: state_next = ST_SCMP;
            ST_SCMP: begin
                if (j_reg == st.s) begin
                    state_next = ST_SEND;
                end else begin
                    state_next = ST_SRD;
                    j_next     = j_reg + 1'b1;
                end
            end
            ST_SEND: begin
                if (st.j1_zero) begin
                    state_next = ST_PCHK;
                    g_next     = '0;
                end else begin
                    state_next = ST_URD;
                    j_next     = '0;
                end
            end
            ST_URD: state_next = ST_UB;
            ST_UB: begin
                if (st.used_j) begin
                    state_next = ST_UC;
                end else if (j_reg == st.s) begin
                    state_next = ST_GNXT;
                end else begin
                    state_next = ST_URD;
                    j_next     = j_reg + 1'b1;
                end
            end
            ST_UC: begin
                if (j_reg == st.s) begin
                    state_next = ST_GNXT;
                end else begin
                    state_next = ST_URD;
                    j_next     = j_reg + 1'b1;
                end
            end
            ST_GNXT: begin
                if (g_reg == st.s) begin
                    state_next = ST_PCHK;
                    g_next     = '0;
                end else begin
                    state_next = ST_GRD;
                    g_next     = g_reg + 1'b1;
                end
            end
            ST_PCHK: begin
                if (st.j0_zero || (g_reg > st.s)) state_next = ST_NXT;
                else state_next = ST_PRD;
            end
            ST_PRD: state_next = ST_PP;
            ST_PP:  state_next = ST_PW;
            ST_PW: begin
                state_next = ST_PCHK;
                g_next     = g_reg + 1'b1;
            end
            ST_NXT: begin
                if (i_reg == st.s) begin
                    state_next = ST_OCLR;
                end else begin
                    state_next = ST_PH;
                    i_next     = i_reg + 1'b1;
                end
            end
            ST_OCLR: begin
                state_next = ST_ORD;
                j_next     = hmca_pkg::cnt_t'(1);
            end
            ST_ORD: state_next = ST_OW;
            ST_OW: begin
                if (j_reg == st.s) begin
                    state_next = ST_TRD;
                    j_next     = '0;
                end else begin
                    state_next = ST_ORD;
                    j_next     = j_reg + 1'b1;
                end
            end
            ST_TRD: state_next = ST_TLD;
            ST_TLD: state_next = ST_TWAIT;
            ST_TWAIT: begin
                if (st.out_acc) begin
                    if (j_reg == st.n - 1'b1) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_TRD;
                        j_next     = j_reg + 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            j_reg     <= '0;
            i_reg     <= '0;
            g_reg     <= '0;
        end else begin
            state_reg <= state_next;
            j_reg     <= j_next;
            i_reg     <= i_next;
            g_reg     <= g_next;
        end
    end

    always_comb begin
        cmd.j = j_reg;
        cmd.i = i_reg;
        unique case (state_reg)
            ST_IDLE:  cmd.op = hmca_pkg::OP_IDLE;
            ST_START: cmd.op = hmca_pkg::OP_START;
            ST_CLR:   cmd.op = hmca_pkg::OP_CLR;
            ST_PH:    cmd.op = hmca_pkg::OP_PH;
            ST_MINI:  cmd.op = hmca_pkg::OP_MINI;
            ST_GRD:   cmd.op = hmca_pkg::OP_GRD;
            ST_GCHK:  cmd.op = hmca_pkg::OP_GCHK;
            ST_SRD:   cmd.op = hmca_pkg::OP_SRD;
            ST_SCUR:  cmd.op = hmca_pkg::OP_SCUR;
            ST_SCMP:  cmd.op = hmca_pkg::OP_SCMP;
            ST_URD:   cmd.op = hmca_pkg::OP_URD;
            ST_UB:    cmd.op = hmca_pkg::OP_UB;
            ST_UC:    cmd.op = hmca_pkg::OP_UC;
            ST_GNXT:  cmd.op = hmca_pkg::OP_GNXT;
            ST_PRD:   cmd.op = hmca_pkg::OP_PRD;
            ST_PP:    cmd.op = hmca_pkg::OP_PP;
            ST_PW:    cmd.op = hmca_pkg::OP_PW;
            ST_OCLR:  cmd.op = hmca_pkg::OP_OCLR;
            ST_ORD:   cmd.op = hmca_pkg::OP_ORD;
            ST_OW:    cmd.op = hmca_pkg::OP_OW;
            ST_TRD:   cmd.op = hmca_pkg::OP_TRD;
            ST_TLD:   cmd.op = hmca_pkg::OP_TLD;
            ST_TWAIT: cmd.op = hmca_pkg::OP_TWAIT;
            default:  cmd.op = hmca_pkg::OP_NOP;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

// ===== src/hmca_dp.sv =====
// Datapath: cost store, potentials, owners, slacks and result registers.
// Depends on hmca_pkg; driven by hmca_ctrl commands.
module hmca_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_acc,
    input  hmca_pkg::idx_t                       s_row,
    input  hmca_pkg::idx_t                       s_col,
    input  logic signed [hmca_pkg::COST_W-1:0]   s_cost,
    input  logic                                 cfg_we,
    input  logic [0:0]                           cfg_idx,
    input  logic [hmca_pkg::CFG_W-1:0]           cfg_val,
    input  logic                                 m_ready,
    input  hmca_pkg::cmd_t                       cmd,
    output hmca_pkg::stat_t                      st,
    output logic                                 m_valid,
    output hmca_pkg::idx_t                       m_row,
    output hmca_pkg::idx_t                       m_col,
    output logic                                 m_has,
    output logic                                 m_last
);

    localparam int SQ = hmca_pkg::MAX_SIZE * hmca_pkg::MAX_SIZE;
    localparam int DP = hmca_pkg::MAX_SIZE + 1;

    // storage
    logic signed [hmca_pkg::COST_W-1:0] cost_mem [SQ];
    hmca_pkg::pot_t u_mem    [DP];
    hmca_pkg::pot_t v_mem    [DP];
    hmca_pkg::pot_t minv_mem [DP];
    hmca_pkg::cnt_t p_mem    [DP];
    hmca_pkg::cnt_t way_mem  [DP];
    hmca_pkg::idx_t asg_mem  [hmca_pkg::MAX_SIZE];

    logic signed [hmca_pkg::COST_W-1:0] cost_rd;
    hmca_pkg::pot_t u_rd, v_rd, minv_rd;
    hmca_pkg::cnt_t p_rd, way_rd;
    hmca_pkg::idx_t asg_rd;

    // control / payload registers
    hmca_pkg::cnt_t rows_reg, cols_reg;
    hmca_pkg::cnt_t n_reg, m_reg, s_reg;
    hmca_pkg::cnt_t i0_reg, j0_reg, j1_reg, jp_reg;
    hmca_pkg::pot_t delta_reg, cur_reg;
    logic [hmca_pkg::MAX_SIZE:0]   used_reg;
    logic [hmca_pkg::MAX_SIZE-1:0] vld_reg;
    logic           m_valid_reg;
    hmca_pkg::idx_t m_row_reg, m_col_reg;
    logic           m_has_reg, m_last_reg;

    // port controls
    logic u_we, v_we, p_we, minv_we, way_we, asg_we, cost_re;
    logic u_re, v_re, p_re, minv_re, way_re, asg_re;
    hmca_pkg::cnt_t u_wa, u_ra, p_wa, p_ra, p_wd;
    hmca_pkg::pot_t u_wd, v_wd, minv_wd;

    // derived values
    hmca_pkg::cnt_t n_c, m_c, i0m1, jm1, pm1, jp_calc;
    logic           forbid, used_j, asg_ok;
    hmca_pkg::pot_t entry_v, cur_calc, newmin;

    assign n_c     = hmca_pkg::clamp_dim(rows_reg);
    assign m_c     = hmca_pkg::clamp_dim(cols_reg);
    assign i0m1    = i0_reg - 1'b1;
    assign jm1     = cmd.j - 1'b1;
    assign pm1     = p_rd - 1'b1;
    assign used_j  = used_reg[cmd.j];
    assign forbid  = (i0_reg > n_reg) || (cmd.j > m_reg) || cost_rd[hmca_pkg::COST_W-1];
    assign entry_v = forbid ? hmca_pkg::FORBID_COST : hmca_pkg::POT_W'(cost_rd);
    assign cur_calc = entry_v - u_rd - v_rd;
    assign newmin  = (cur_reg < minv_rd) ? cur_reg : minv_rd;
    assign jp_calc = (way_rd > s_reg) ? '0 : way_rd;
    assign asg_ok  = (p_rd != '0) && (p_rd <= n_reg) && (cmd.j <= m_reg);

    always_comb begin
        u_we = 1'b0; v_we = 1'b0; p_we = 1'b0; minv_we = 1'b0; way_we = 1'b0;
        asg_we = 1'b0; cost_re = 1'b0;
        u_re = 1'b0; v_re = 1'b0; p_re = 1'b0; minv_re = 1'b0; way_re = 1'b0;
        asg_re = 1'b0;
        u_wa = cmd.j; u_ra = p_rd; p_wa = cmd.j; p_ra = cmd.j; p_wd = '0;
        u_wd = '0; v_wd = '0; minv_wd = hmca_pkg::P_INF;
        unique case (cmd.op)
            hmca_pkg::OP_CLR: begin
                u_we = 1'b1; v_we = 1'b1; p_we = 1'b1;
            end
            hmca_pkg::OP_PH: begin
                p_we = 1'b1; p_wa = '0; p_wd = cmd.i;
            end
            hmca_pkg::OP_MINI: minv_we = 1'b1;
            hmca_pkg::OP_GRD: begin
                p_re = 1'b1; p_ra = j0_reg;
            end
            hmca_pkg::OP_GCHK: u_re = !st.i0_bad;
            hmca_pkg::OP_SRD: begin
                minv_re = 1'b1; v_re = 1'b1; cost_re = 1'b1;
            end
            hmca_pkg::OP_SCMP: begin
                if (cur_reg < minv_rd) begin
                    minv_we = 1'b1; minv_wd = cur_reg; way_we = 1'b1;
                end
            end
            hmca_pkg::OP_URD: begin
                p_re = 1'b1; v_re = 1'b1; minv_re = 1'b1;
            end
            hmca_pkg::OP_UB: begin
                if (used_j) begin
                    v_we = 1'b1; v_wd = v_rd - delta_reg; u_re = 1'b1;
                end else begin
                    minv_we = 1'b1; minv_wd = minv_rd - delta_reg;
                end
            end
            hmca_pkg::OP_UC: begin
                u_we = (p_rd <= s_reg); u_wa = p_rd; u_wd = u_rd + delta_reg;
            end
            hmca_pkg::OP_PRD: way_re = 1'b1;
            hmca_pkg::OP_PP: begin
                p_re = 1'b1; p_ra = jp_calc;
            end
            hmca_pkg::OP_PW: begin
                p_we = 1'b1; p_wa = j0_reg; p_wd = p_rd;
            end
            hmca_pkg::OP_ORD: p_re = 1'b1;
            hmca_pkg::OP_OW:  asg_we = asg_ok;
            hmca_pkg::OP_TRD: asg_re = 1'b1;
            default: ;
        endcase
    end

    // memories: one write and one registered read port each
    always_ff @(posedge aclk) begin
        if (s_acc) cost_mem[{s_row, s_col}] <= s_cost;
        if (cost_re) cost_rd <= cost_mem[{i0m1[hmca_pkg::IDX_W-1:0], jm1[hmca_pkg::IDX_W-1:0]}];
    end

    always_ff @(posedge aclk) begin
        if (u_we) u_mem[u_wa] <= u_wd;
        if (u_re) u_rd <= u_mem[u_ra];
    end

    always_ff @(posedge aclk) begin
        if (v_we) v_mem[cmd.j] <= v_wd;
        if (v_re) v_rd <= v_mem[cmd.j];
    end

    always_ff @(posedge aclk) begin
        if (minv_we) minv_mem[cmd.j] <= minv_wd;
        if (minv_re) minv_rd <= minv_mem[cmd.j];
    end

    always_ff @(posedge aclk) begin
        if (p_we) p_mem[p_wa] <= p_wd;
        if (p_re) p_rd <= p_mem[p_ra];
    end

    always_ff @(posedge aclk) begin
        if (way_we) way_mem[cmd.j] <= j0_reg;
        if (way_re) way_rd <= way_mem[j0_reg];
    end

    always_ff @(posedge aclk) begin
        if (asg_we) asg_mem[pm1[hmca_pkg::IDX_W-1:0]] <= jm1[hmca_pkg::IDX_W-1:0];
        if (asg_re) asg_rd <= asg_mem[cmd.j[hmca_pkg::IDX_W-1:0]];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg    <= hmca_pkg::cnt_t'(hmca_pkg::MAX_SIZE);
            cols_reg    <= hmca_pkg::cnt_t'(hmca_pkg::MAX_SIZE);
            used_reg    <= '0;
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_idx)
                    hmca_pkg::REG_ROWS: rows_reg <= cfg_val;
                    hmca_pkg::REG_COLS: cols_reg <= cfg_val;
                    default: ;
                endcase
            end
            if (cmd.op == hmca_pkg::OP_PH) used_reg <= '0;
            else if (cmd.op == hmca_pkg::OP_GRD) used_reg[j0_reg] <= 1'b1;
            if (cmd.op == hmca_pkg::OP_OCLR) vld_reg <= '0;
            else if (asg_we) vld_reg[pm1[hmca_pkg::IDX_W-1:0]] <= 1'b1;
            if (cmd.op == hmca_pkg::OP_TLD) m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            hmca_pkg::OP_START: begin
                n_reg <= n_c;
                m_reg <= m_c;
                s_reg <= (n_c > m_c) ? n_c : m_c;
            end
            hmca_pkg::OP_PH: j0_reg <= '0;
            hmca_pkg::OP_GCHK: begin
                i0_reg    <= p_rd;
                delta_reg <= hmca_pkg::P_INF;
                j1_reg    <= '0;
            end
            hmca_pkg::OP_SCUR: cur_reg <= cur_calc;
            hmca_pkg::OP_SCMP: begin
                if (newmin < delta_reg) begin
                    delta_reg <= newmin;
                    j1_reg    <= cmd.j;
                end
            end
            hmca_pkg::OP_GNXT: j0_reg <= j1_reg;
            hmca_pkg::OP_PP:   jp_reg <= jp_calc;
            hmca_pkg::OP_PW:   j0_reg <= jp_reg;
            hmca_pkg::OP_TLD: begin
                m_row_reg  <= cmd.j[hmca_pkg::IDX_W-1:0];
                m_col_reg  <= vld_reg[cmd.j[hmca_pkg::IDX_W-1:0]] ? asg_rd : '0;
                m_has_reg  <= vld_reg[cmd.j[hmca_pkg::IDX_W-1:0]];
                m_last_reg <= (cmd.j == n_reg - 1'b1);
            end
            default: ;
        endcase
    end

    assign st.s       = s_reg;
    assign st.n       = n_reg;
    assign st.used_j  = used_j;
    assign st.i0_bad  = (p_rd == '0) || (p_rd > s_reg);
    assign st.j1_zero = (j1_reg == '0);
    assign st.j0_zero = (j0_reg == '0);
    assign st.out_acc = m_valid_reg && m_ready;

    assign m_valid = m_valid_reg;
    assign m_row   = m_row_reg;
    assign m_col   = m_col_reg;
    assign m_has   = m_has_reg;
    assign m_last  = m_last_reg;

endmodule

// ===== src/hungarian_min_cost_assignment_top.sv =====
// Top level of the min-cost assignment block (Hungarian method, potentials).
// Depends on hmca_pkg, hmca_ctrl, hmca_dp.
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_tvalid/s_tready  | tdata: row, column, cost; tlast: final_entry
//   m_      | out       | m_tvalid/m_tready  | tdata: row_index, assigned_column;
//           |           |                    | tuser: has_column; tlast: last_result
//   cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
// Loading takes one item per cycle while s_tready is high. The item with tlast starts a solve on a square of
// size S = max(rows, cols): the potentials are cleared, then per row the slacks are initialised,
// up to S+1 search rounds run, each a slack scan and a potential update over S+1 columns,
// and the augmenting steps walk back along the path.
// Then the row map is built and each result is read, loaded and held until taken. No clearing
// pass after reset; s_tready is low from the final item until the last result is taken.
module hungarian_min_cost_assignment_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [5:0] row, [11:6] column, [35:12] cost, rest zero
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [5:0] row_index, [11:6] assigned_column, rest zero
    output logic [0:0]  m_tuser,   // [0] has_column
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    hmca_pkg::cmd_t  cmd;
    hmca_pkg::stat_t st;
    hmca_pkg::idx_t  m_row, m_col;
    logic            s_acc, m_has, m_last;

    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    hmca_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_acc   (s_acc),
        .s_final (s_tlast),
        .st      (st),
        .cmd     (cmd),
        .s_ready (s_tready)
    );

    hmca_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_acc   (s_acc),
        .s_row   (s_tdata[5:0]),
        .s_col   (s_tdata[11:6]),
        .s_cost  (s_tdata[35:12]),
        .cfg_we  (cfg_valid && cfg_ready),
        .cfg_idx (cfg_index),
        .cfg_val (cfg_data),
        .m_ready (m_tready),
        .cmd     (cmd),
        .st      (st),
        .m_valid (m_tvalid),
        .m_row   (m_row),
        .m_col   (m_col),
        .m_has   (m_has),
        .m_last  (m_last)
    );

    assign m_tdata = {4'b0000, m_col, m_row};
    assign m_tuser = m_has;
    assign m_tlast = m_last;

endmodule

// ===== src/hmca_checker.sv =====
// Port-level checks for the min-cost assignment top, attached by bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module hmca_port_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // no load while a result is pending
    `ASSERT_IMPLIES(a_no_load_during_out, aclk, aresetn, m_tvalid, !s_tready)
    // final item starts the solve
    `ASSERT_NEXT(a_busy_after_final, aclk, aresetn, s_tvalid && s_tready && s_tlast, !s_tready)
    // last result taken: back to loading
    `ASSERT_NEXT(a_idle_after_last, aclk, aresetn, m_tvalid && m_tready && m_tlast, !m_tvalid && s_tready)
    // stalled result holds
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind hungarian_min_cost_assignment_top hmca_port_checker u_hmca_checker (.*);
